>>> sv/ptg_pkg.sv
package ptg_pkg;

    localparam int CH_W     = 3;
    localparam int SEC_W    = 24;
    localparam int RATE_W   = 18;
    localparam int RECIP_W  = 32;
    localparam int PHASE_W  = 48;
    localparam int MAG_W    = 41;
    localparam int DLY_W    = 42;
    localparam int TIME_W   = 32;
    localparam int MUL_W    = 32;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 32;

    localparam logic [CFG_A_W-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_RATE_RECIP  = 1'b1;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd89478;

    localparam logic signed [PHASE_W-1:0] ONE_SAMPLE = 48'sh0000_0001_0000;
    localparam logic signed [PHASE_W-1:0] PHASE_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [PHASE_W-1:0] SAT_LIMIT  = PHASE_MAX - ONE_SAMPLE;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic                    restart;
        logic signed [SEC_W-1:0] interval_seconds;
        logic signed [SEC_W-1:0] delay_seconds;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic              trigger;
        logic [TIME_W-1:0] elapsed_time;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic done;
    } rem_ctl_t;

endpackage

>>> sv/ptg_mult.sv
module ptg_mult (
    input  logic                          aclk,
    input  logic [ptg_pkg::MUL_W-1:0]     a,
    input  logic [ptg_pkg::MUL_W-1:0]     b,
    output logic [2*ptg_pkg::MUL_W-1:0]   p
);

    logic [2*ptg_pkg::MUL_W-1:0] p_reg;

    // one product per cycle, registered
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> sv/ptg_rem.sv
module ptg_rem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ptg_pkg::PHASE_W-1:0]  dividend,
    input  logic [ptg_pkg::MAG_W-1:0]    divisor,
    output logic                         done,
    output logic [ptg_pkg::MAG_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(ptg_pkg::PHASE_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [ptg_pkg::PHASE_W-1:0]  dvd_reg;
    logic [ptg_pkg::MAG_W:0]      rem_reg;
    logic [ptg_pkg::MAG_W:0]      trial;
    logic [ptg_pkg::MAG_W:0]      rem_next;

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        trial = {rem_reg[ptg_pkg::MAG_W-1:0], dvd_reg[ptg_pkg::PHASE_W-1]};
        if (trial >= {1'b0, divisor}) begin
            rem_next = trial - {1'b0, divisor};
        end else begin
            rem_next = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ptg_pkg::PHASE_W - 1);
                dvd_reg  <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[ptg_pkg::PHASE_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[ptg_pkg::MAG_W-1:0];

endmodule

>>> sv/periodic_trigger_generator.sv
// Channel   Direction  Signals                                  Payload
// s_        in         s_valid, s_ready, s_data                 ptg_pkg::in_item_t
// m_        out        m_valid, m_ready, m_data                 ptg_pkg::out_item_t
// cfg_      in         cfg_valid, cfg_ready, cfg_addr, cfg_data register write
//
// An item runs from transfer to result through the sequencer states S_IVL to S_OUT;
// when the phase needs a wrap it also runs a 48-step bit-serial remainder unit (S_DIV).
// The four multiplies go one after another through a single 32x32 multiplier.
// Synchronous active-low reset restores the registers and clears all phases.
// A finished result sits in the output register; the next input transfer is
// taken while it waits, and the sequencer holds only if a second result is ready
// before the first is taken.
module periodic_trigger_generator #(
    parameter int CHANNELS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  ptg_pkg::in_item_t             s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output ptg_pkg::out_item_t            m_data,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptg_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [ptg_pkg::CFG_D_W-1:0]   cfg_data
);

    localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHX_W = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IVL,
        S_DLY,
        S_DSGN,
        S_DIFF,
        S_CHECK,
        S_DIV,
        S_TLO,
        S_THI,
        S_SUM,
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [ptg_pkg::RATE_W-1:0]  rate_reg;
    logic [ptg_pkg::RECIP_W-1:0] recip_reg;

    // per-channel phase counters, Q31.16
    logic signed [ptg_pkg::PHASE_W-1:0] phase_reg [CHANNELS];

    // working registers for the item in flight
    logic [SEL_W-1:0]                   sel_reg;
    logic [ptg_pkg::CH_W-1:0]           ch_reg;
    logic                               restart_reg;
    logic                               dly_neg_reg;
    logic [ptg_pkg::SEC_W-1:0]          ivl_abs_reg;
    logic [ptg_pkg::SEC_W-1:0]          dly_abs_reg;
    logic [ptg_pkg::MAG_W-1:0]          mag_reg;
    logic signed [ptg_pkg::DLY_W-1:0]   dly_reg;
    logic signed [ptg_pkg::PHASE_W:0]   d_reg;
    logic signed [ptg_pkg::PHASE_W-1:0] idx_reg;
    logic [ptg_pkg::RECIP_W-1:0]        lo_acc_reg;
    logic                               trig_reg;
    logic [ptg_pkg::TIME_W-1:0]         elapsed_reg;

    // output register
    logic                               m_valid_reg;
    ptg_pkg::out_item_t                 m_data_reg;

    // shared multiplier
    logic [ptg_pkg::MUL_W-1:0]          mul_a;
    logic [ptg_pkg::MUL_W-1:0]          mul_b;
    logic [2*ptg_pkg::MUL_W-1:0]        mul_p;

    // remainder unit
    ptg_pkg::rem_ctl_t                  rem_ctl;
    logic [ptg_pkg::MAG_W-1:0]          rem_val;

    logic [CHX_W-1:0]                   ch_wide;
    logic                               ch_ok;
    logic [ptg_pkg::SEC_W-1:0]          ivl_abs;
    logic [ptg_pkg::SEC_W-1:0]          dly_abs;
    logic                               do_clear;
    logic                               do_wrap;
    logic [ptg_pkg::PHASE_W-1:0]        time_sum;
    logic                               idx_pos;
    logic signed [ptg_pkg::PHASE_W-1:0] idx_inc;
    logic                               s_xfer;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign ch_wide = {4'b0000, s_data.channel};
    assign ch_ok   = (ch_wide < CHX_W'(CHANNELS));

    // magnitudes of the Q7.16 inputs; -2^23 maps to 2^23 unsigned
    always_comb begin
        if (s_data.interval_seconds[ptg_pkg::SEC_W-1]) begin
            ivl_abs = ~s_data.interval_seconds + 1'b1;
        end else begin
            ivl_abs = s_data.interval_seconds;
        end
        if (s_data.delay_seconds[ptg_pkg::SEC_W-1]) begin
            dly_abs = ~s_data.delay_seconds + 1'b1;
        end else begin
            dly_abs = s_data.delay_seconds;
        end
    end

    // operand select for the shared multiplier; product shows up next state
    always_comb begin
        case (state_reg)
            S_IVL: begin
                mul_a = {8'b0, ivl_abs_reg};
                mul_b = {14'b0, rate_reg};
            end
            S_DLY: begin
                mul_a = {8'b0, dly_abs_reg};
                mul_b = {14'b0, rate_reg};
            end
            S_TLO: begin
                mul_a = idx_reg[31:0];
                mul_b = recip_reg;
            end
            S_THI: begin
                mul_a = {16'b0, idx_reg[ptg_pkg::PHASE_W-1:32]};
                mul_b = recip_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // restart or zero scaled interval clears the phase; otherwise wrap once
    // (phase - delay) has reached the interval
    assign do_clear      = restart_reg || (mag_reg == '0);
    assign do_wrap       = !do_clear && (d_reg >= $signed({8'b0, mag_reg}));
    assign rem_ctl.start = (state_reg == S_CHECK) && do_wrap;

    // elapsed time = hi*recip + (lo*recip >> 32)
    assign time_sum = mul_p[ptg_pkg::PHASE_W-1:0] + {16'b0, lo_acc_reg};
    assign idx_pos  = !idx_reg[ptg_pkg::PHASE_W-1] && (idx_reg != '0);
    assign idx_inc  = (idx_reg >= ptg_pkg::SAT_LIMIT) ? ptg_pkg::PHASE_MAX
                                                      : idx_reg + ptg_pkg::ONE_SAMPLE;

    ptg_mult u_mult (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    ptg_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_ctl.start),
        .dividend  (d_reg[ptg_pkg::PHASE_W-1:0]),
        .divisor   (mag_reg),
        .done      (rem_ctl.done),
        .remainder (rem_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rate_reg    <= ptg_pkg::RATE_RESET;
            recip_reg   <= ptg_pkg::RECIP_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                phase_reg[i] <= '0;
            end
        end else begin
            // configuration writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    ptg_pkg::CFG_SAMPLE_RATE: rate_reg  <= cfg_data[ptg_pkg::RATE_W-1:0];
                    ptg_pkg::CFG_RATE_RECIP:  recip_reg <= cfg_data[ptg_pkg::RECIP_W-1:0];
                    default: ;
                endcase
            end

            // drop the output once it has been taken; S_OUT reloads it itself
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        ch_reg      <= s_data.channel;
                        restart_reg <= s_data.restart;
                        ivl_abs_reg <= ivl_abs;
                        dly_abs_reg <= dly_abs;
                        dly_neg_reg <= s_data.delay_seconds[ptg_pkg::SEC_W-1];
                        sel_reg     <= ch_wide[SEL_W-1:0];
                        if (ch_ok) begin
                            idx_reg   <= phase_reg[ch_wide[SEL_W-1:0]];
                            state_reg <= S_IVL;
                        end else begin
                            // unknown channel: report no trigger and zero time, touch no phase
                            trig_reg    <= 1'b0;
                            elapsed_reg <= '0;
                            state_reg   <= S_OUT;
                        end
                    end
                end
                S_IVL: begin
                    state_reg <= S_DLY;
                end
                S_DLY: begin
                    mag_reg   <= mul_p[ptg_pkg::MAG_W-1:0];
                    state_reg <= S_DSGN;
                end
                S_DSGN: begin
                    if (dly_neg_reg) begin
                        dly_reg <= (~mul_p[ptg_pkg::DLY_W-1:0]) + 1'b1;
                    end else begin
                        dly_reg <= mul_p[ptg_pkg::DLY_W-1:0];
                    end
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    d_reg <= {idx_reg[ptg_pkg::PHASE_W-1], idx_reg}
                           - {{7{dly_reg[ptg_pkg::DLY_W-1]}}, dly_reg};
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (do_clear) begin
                        idx_reg   <= '0;
                        state_reg <= S_TLO;
                    end else if (do_wrap) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_TLO;
                    end
                end
                S_DIV: begin
                    // phase = delay + (phase - delay) mod interval
                    if (rem_ctl.done) begin
                        idx_reg   <= {{6{dly_reg[ptg_pkg::DLY_W-1]}}, dly_reg}
                                   + {7'b0, rem_val};
                        state_reg <= S_TLO;
                    end
                end
                S_TLO: begin
                    state_reg <= S_THI;
                end
                S_THI: begin
                    lo_acc_reg <= mul_p[2*ptg_pkg::MUL_W-1:ptg_pkg::MUL_W];
                    state_reg  <= S_SUM;
                end
                S_SUM: begin
                    trig_reg <= (idx_reg < ptg_pkg::ONE_SAMPLE);
                    if (!idx_pos) begin
                        elapsed_reg <= '0;
                    end else if (time_sum[ptg_pkg::PHASE_W-1:ptg_pkg::TIME_W] != '0) begin
                        elapsed_reg <= '1;
                    end else begin
                        elapsed_reg <= time_sum[ptg_pkg::TIME_W-1:0];
                    end
                    // advance one sample, saturating
                    phase_reg[sel_reg] <= idx_inc;
                    state_reg          <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.out_channel  <= ch_reg;
                        m_data_reg.trigger      <= trig_reg;
                        m_data_reg.elapsed_time <= elapsed_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
